### rtl/core/rapc_pkg.sv
// ============================================================================
// rapc_pkg: shared types and constants for the register action plan checker
// Holds the action kinds, the denial codes and the records that pass between
// the classifier, the action queue and the plan tracker.
// ============================================================================
package rapc_pkg;

    // Counter limits
    localparam int MAX_ACTIONS = 4096;
    localparam int CNT_W       = $clog2(MAX_ACTIONS + 1);

    // Input field widths
    localparam int KIND_W  = 3;
    localparam int WORD_W  = 32;
    localparam int LIMIT_W = 16;
    localparam int CODE_W  = 3;

    // Engine windows
    localparam int          OFS_W       = 13;
    localparam logic [31:0] WIN_A_BASE  = 32'h0011_0000;
    localparam logic [31:0] WIN_B_BASE  = 32'h0084_0000;
    localparam logic [OFS_W-1:0] CPU_CTL_OFS = 13'h0100;

    // Configuration register reset values
    localparam logic [LIMIT_W-1:0] POLL_LIMIT_RST  = 16'd60000;
    localparam logic [LIMIT_W-1:0] DELAY_LIMIT_RST = 16'd10000;

    // Configuration register indexes
    localparam logic CFG_POLL_LIMIT  = 1'b0;
    localparam logic CFG_DELAY_LIMIT = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE        = 3'd0,
        KIND_MASKED_WRITE = 3'd1,
        KIND_POLL         = 3'd2,
        KIND_IF_BEGIN     = 3'd3,
        KIND_DELAY        = 3'd4,
        KIND_START_CPU    = 3'd5,
        KIND_END_IF       = 3'd6,
        KIND_END_PLAN     = 3'd7
    } t_kind;

    typedef enum logic [CODE_W-1:0] {
        DENY_NONE    = 3'd0,
        DENY_ADDR    = 3'd1,
        DENY_MASK    = 3'd2,
        DENY_VALUE   = 3'd3,
        DENY_TIMEOUT = 3'd4,
        DENY_FLOW    = 3'd5,
        DENY_ALIAS   = 3'd6
    } t_deny;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        logic  is_end;
        logic  plan_valid;
        logic  is_if_begin;
        logic  is_end_if;
        t_deny code;
    } t_act;

    // One plan report.
    typedef struct packed {
        logic             plan_allowed;
        logic [CNT_W-1:0] first_denied_index;
        t_deny            denial_code;
        logic             needs_cpu_alias_start;
        logic [CNT_W-1:0] action_count;
    } t_report;

    // Handshake between the action queue and the plan tracker.
    typedef struct packed {
        logic valid;
        t_act item;
    } t_act_head;

endpackage

### rtl/core/register_action_plan_checker_unit.sv
// ============================================================================
// register_action_plan_checker_unit: register-access firewall for action plans
// Classifies each action against the engine windows and rule tables, tracks
// the plan and reports once per end-of-plan item.
// ============================================================================
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+---------------------------
//  actions   | in        | push / full            | kind, address, value, mask,
//            |           |                        | timeout_ms, plan_valid
//  reports   | out       | empty / pop            | plan_allowed, first_denied
//            |           |                        | _index, denial_code, needs
//            |           |                        | _cpu_alias_start, action_count
//  config    | in        | i_cfg_we (no wait)     | i_cfg_idx, i_cfg_data
//
// One action is taken every cycle while the action queue is not full. The
// classifier checks an item in the cycle it is accepted and writes it into a
// two-entry queue; the plan tracker takes one item per cycle from it unless
// stalled and writes each report into a two-entry report queue, which stalls
// the tracker only on end-of-plan items. Reset is synchronous, clears the
// queues and the plan state and reloads the limit registers.
//
module register_action_plan_checker_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [rapc_pkg::LIMIT_W-1:0]   i_cfg_data,
    // Actions
    input  logic                           push,
    output logic                           full,
    input  logic [rapc_pkg::KIND_W-1:0]    i_kind,
    input  logic [rapc_pkg::WORD_W-1:0]    i_address,
    input  logic [rapc_pkg::WORD_W-1:0]    i_value,
    input  logic [rapc_pkg::WORD_W-1:0]    i_mask,
    input  logic [rapc_pkg::WORD_W-1:0]    i_timeout_ms,
    input  logic                           i_plan_valid,
    // Reports
    output logic                           empty,
    input  logic                           pop,
    output logic                           o_plan_allowed,
    output logic [rapc_pkg::CNT_W-1:0]     o_first_denied_index,
    output logic [rapc_pkg::CODE_W-1:0]    o_denial_code,
    output logic                           o_needs_cpu_alias_start,
    output logic [rapc_pkg::CNT_W-1:0]     o_action_count
);

    rapc_pkg::t_act        act;
    rapc_pkg::t_act_head   head;
    rapc_pkg::t_report     rpt;
    logic                  act_pop;

    // Classifier.
    rapc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_kind       (i_kind),
        .i_address    (i_address),
        .i_value      (i_value),
        .i_mask       (i_mask),
        .i_timeout_ms (i_timeout_ms),
        .i_plan_valid (i_plan_valid),
        .o_act        (act)
    );

    // Queue between classifier and tracker.
    rapc_act_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (act),
        .o_full  (full),
        .i_pop   (act_pop),
        .o_head  (head)
    );

    // Plan tracker and report queue.
    rapc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_act_pop   (act_pop),
        .i_rpt_pop   (pop),
        .o_rpt_empty (empty),
        .o_rpt       (rpt)
    );

    assign o_plan_allowed          = rpt.plan_allowed;
    assign o_first_denied_index    = rpt.first_denied_index;
    assign o_denial_code           = rpt.denial_code;
    assign o_needs_cpu_alias_start = rpt.needs_cpu_alias_start;
    assign o_action_count          = rpt.action_count;

    // An allowed plan carries no denial.
    a_allowed_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_plan_allowed) |->
            (o_denial_code == rapc_pkg::DENY_NONE && o_first_denied_index == '0))
        else $error("allowed report carries a denial");

    // An end-of-plan item taken by the tracker leaves a report waiting.
    a_report_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (act_pop && head.item.is_end) |=> !empty)
        else $error("end-of-plan item produced no report");

    // A denial never points past the number of actions counted.
    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_first_denied_index <= o_action_count))
        else $error("denied index beyond action count");

    // The tracker only takes an item when the queue holds one.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        act_pop |-> head.valid)
        else $error("tracker popped an empty queue");

endmodule

### rtl/core/rapc_front.sv
// ============================================================================
// rapc_front: action classifier
// Holds the limit registers and runs the per-action checks on each item,
// producing the denial code that the plan tracker acts on.
// ============================================================================
module rapc_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [rapc_pkg::LIMIT_W-1:0]   i_cfg_data,
    input  logic [rapc_pkg::KIND_W-1:0]    i_kind,
    input  logic [rapc_pkg::WORD_W-1:0]    i_address,
    input  logic [rapc_pkg::WORD_W-1:0]    i_value,
    input  logic [rapc_pkg::WORD_W-1:0]    i_mask,
    input  logic [rapc_pkg::WORD_W-1:0]    i_timeout_ms,
    input  logic                           i_plan_valid,
    output rapc_pkg::t_act                 o_act
);

    typedef struct packed {
        logic        hit;
        logic [31:0] mask;
    } t_rule;

    // Write rule table lookup.
    function automatic t_rule wr_rule(input logic [rapc_pkg::OFS_W-1:0] ofs);
        t_rule r;
        r.hit  = 1'b1;
        r.mask = '0;
        unique case (ofs)
            13'h03C0: r.mask = 32'h0000_0001;
            13'h1668: r.mask = 32'h0000_0111;
            13'h0084: r.mask = 32'hFFFF_FFFF;
            13'h0624: r.mask = 32'h0000_0080;
            13'h010C: r.mask = 32'h0000_0007;
            13'h0600: r.mask = 32'h0000_0007;
            13'h0110: r.mask = 32'hFFFF_FFFF;
            13'h0128: r.mask = 32'h0000_01FF;
            13'h0114: r.mask = 32'h00FF_FFFF;
            13'h011C: r.mask = 32'hFFFF_FFFF;
            13'h0118: r.mask = 32'h0001_773F;
            13'h1210: r.mask = 32'hFFFF_FFFF;
            13'h119C: r.mask = 32'hFFFF_FFFF;
            13'h1198: r.mask = 32'h0000_00FF;
            13'h1180: r.mask = 32'h0000_00FF;
            13'h0104: r.mask = 32'hFFFF_FFFF;
            13'h0040: r.mask = 32'hFFFF_FFFF;
            13'h0044: r.mask = 32'hFFFF_FFFF;
            default:  r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    // Read rule table lookup.
    function automatic t_rule rd_rule(input logic [rapc_pkg::OFS_W-1:0] ofs);
        t_rule r;
        r.hit  = 1'b1;
        r.mask = '0;
        unique case (ofs)
            13'h00F4: r.mask = 32'h0000_1400;
            13'h0118: r.mask = 32'h0000_0003;
            13'h1668: r.mask = 32'h0000_0111;
            13'h0100: r.mask = 32'hFFFF_FFFF;
            default:  r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    logic [rapc_pkg::LIMIT_W-1:0] r_poll_limit;
    logic [rapc_pkg::LIMIT_W-1:0] r_delay_limit;

    rapc_pkg::t_kind               kind;
    logic                          in_window;
    logic [rapc_pkg::OFS_W-1:0]    ofs;
    t_rule                         rule;
    logic                          is_write;
    logic                          mask_bad;
    logic                          value_bad;
    logic                          others_zero;
    rapc_pkg::t_deny               code;

    // Limit registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit  <= rapc_pkg::POLL_LIMIT_RST;
            r_delay_limit <= rapc_pkg::DELAY_LIMIT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == rapc_pkg::CFG_POLL_LIMIT) begin
                r_poll_limit <= i_cfg_data;
            end else begin
                r_delay_limit <= i_cfg_data;
            end
        end
    end

    // Window decode shared by all register kinds; rule lookup in the write table for writes, else the read table.
    assign kind      = rapc_pkg::t_kind'(i_kind);
    assign ofs       = i_address[rapc_pkg::OFS_W-1:0];
    assign in_window =
        (i_address[31:rapc_pkg::OFS_W] == rapc_pkg::WIN_A_BASE[31:rapc_pkg::OFS_W]) ||
        (i_address[31:rapc_pkg::OFS_W] == rapc_pkg::WIN_B_BASE[31:rapc_pkg::OFS_W]);
    assign is_write  = (kind == rapc_pkg::KIND_WRITE) || (kind == rapc_pkg::KIND_MASKED_WRITE);
    assign rule      = is_write ? wr_rule(ofs) : rd_rule(ofs);
    assign mask_bad  = (i_mask == '0) || ((i_mask & ~rule.mask) != '0);
    assign value_bad = (i_value & ~i_mask) != '0;
    assign others_zero = (i_value == '0) && (i_mask == '0) && (i_timeout_ms == '0);

    // Per-action checks in the order of precedence.
    always_comb begin
        code = rapc_pkg::DENY_NONE;
        unique case (kind)
            rapc_pkg::KIND_WRITE, rapc_pkg::KIND_MASKED_WRITE,
            rapc_pkg::KIND_POLL, rapc_pkg::KIND_IF_BEGIN: begin
                priority if (!in_window || !rule.hit) begin
                    code = rapc_pkg::DENY_ADDR;
                end else if (mask_bad) begin
                    code = rapc_pkg::DENY_MASK;
                end else if (value_bad) begin
                    code = rapc_pkg::DENY_VALUE;
                end else if (kind == rapc_pkg::KIND_POLL) begin
                    if ((i_timeout_ms == '0) ||
                        (i_timeout_ms > {{(rapc_pkg::WORD_W-rapc_pkg::LIMIT_W){1'b0}},
                                         r_poll_limit})) begin
                        code = rapc_pkg::DENY_TIMEOUT;
                    end
                end else begin
                    if (i_timeout_ms != '0) begin
                        code = rapc_pkg::DENY_TIMEOUT;
                    end
                end
            end
            rapc_pkg::KIND_DELAY: begin
                if ((i_address != '0) || (i_mask != '0) || (i_timeout_ms != '0) ||
                    (i_value == '0) ||
                    (i_value > {{(rapc_pkg::WORD_W-rapc_pkg::LIMIT_W){1'b0}},
                                r_delay_limit})) begin
                    code = rapc_pkg::DENY_TIMEOUT;
                end
            end
            rapc_pkg::KIND_START_CPU: begin
                if (!in_window || (ofs != rapc_pkg::CPU_CTL_OFS) || !others_zero) begin
                    code = rapc_pkg::DENY_ADDR;
                end else begin
                    code = rapc_pkg::DENY_ALIAS;
                end
            end
            rapc_pkg::KIND_END_IF: begin
                if ((i_address != '0) || !others_zero) begin
                    code = rapc_pkg::DENY_FLOW;
                end
            end
            rapc_pkg::KIND_END_PLAN: begin
                code = rapc_pkg::DENY_NONE;
            end
        endcase
    end

    // Classified item.
    assign o_act.is_end      = (kind == rapc_pkg::KIND_END_PLAN);
    assign o_act.plan_valid  = i_plan_valid;
    assign o_act.is_if_begin = (kind == rapc_pkg::KIND_IF_BEGIN);
    assign o_act.is_end_if   = (kind == rapc_pkg::KIND_END_IF);
    assign o_act.code        = code;

endmodule

### rtl/core/rapc_act_queue.sv
// ============================================================================
// rapc_act_queue: two-entry queue of classified items
// Decouples the classifier from the plan tracker so each side stalls alone.
// ============================================================================
module rapc_act_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  rapc_pkg::t_act         i_item,
    output logic                   o_full,
    input  logic                   i_pop,
    output rapc_pkg::t_act_head    o_head
);

    rapc_pkg::t_act r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic [1:0]     n_count;
    logic           do_push;
    logic           do_pop;

    assign o_full      = (r_count == 2'd2);
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && (r_count != 2'd0);
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_mem[r_rd_ptr];

    // Occupancy follows pushes and pops.
    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### rtl/core/rapc_back.sv
// ============================================================================
// rapc_back: plan tracker and report queue
// Keeps the per-plan state, latches the first denial, checks conditional
// sections and queues one report for each end-of-plan item.
// ============================================================================
module rapc_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rapc_pkg::t_act_head    i_head,
    output logic                   o_act_pop,
    input  logic                   i_rpt_pop,
    output logic                   o_rpt_empty,
    output rapc_pkg::t_report      o_rpt
);

    logic                         r_inside;
    logic                         r_latched;
    logic [rapc_pkg::CNT_W-1:0]   r_denied_pos;
    rapc_pkg::t_deny              r_denied_code;
    logic                         r_alias_seen;
    logic [rapc_pkg::CNT_W-1:0]   r_seen;

    rapc_pkg::t_report            r_rq [2];
    logic                         r_rq_wr;
    logic                         r_rq_rd;
    logic [1:0]                   r_rq_count;
    logic [1:0]                   n_rq_count;

    logic                         rq_full;
    logic                         fire;
    logic                         rpt_push;
    logic                         rpt_pop;
    rapc_pkg::t_report            report;
    rapc_pkg::t_act               act;

    assign act       = i_head.item;
    assign rq_full   = (r_rq_count == 2'd2);
    assign o_act_pop = i_head.valid && (!act.is_end || !rq_full);
    assign fire      = o_act_pop;
    assign rpt_push  = fire && act.is_end;
    assign rpt_pop   = i_rpt_pop && (r_rq_count != 2'd0);

    // Report built from the current plan state.
    always_comb begin
        report.plan_allowed          = 1'b0;
        report.first_denied_index    = '0;
        report.denial_code           = rapc_pkg::DENY_NONE;
        report.needs_cpu_alias_start = 1'b0;
        report.action_count          = r_seen;
        if (!act.plan_valid) begin
            report.denial_code = rapc_pkg::DENY_FLOW;
        end else begin
            report.needs_cpu_alias_start = r_alias_seen;
            priority if (r_latched) begin
                report.first_denied_index = r_denied_pos;
                report.denial_code        = r_denied_code;
            end else if (r_inside) begin
                report.first_denied_index = r_seen;
                report.denial_code        = rapc_pkg::DENY_FLOW;
            end else begin
                report.plan_allowed = 1'b1;
            end
        end
    end

    // Per-plan state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside      <= 1'b0;
            r_latched     <= 1'b0;
            r_denied_pos  <= '0;
            r_denied_code <= rapc_pkg::DENY_NONE;
            r_alias_seen  <= 1'b0;
            r_seen        <= '0;
        end else if (fire) begin
            if (act.is_end) begin
                r_inside      <= 1'b0;
                r_latched     <= 1'b0;
                r_denied_pos  <= '0;
                r_denied_code <= rapc_pkg::DENY_NONE;
                r_alias_seen  <= 1'b0;
                r_seen        <= '0;
            end else begin
                if (r_seen < rapc_pkg::CNT_W'(rapc_pkg::MAX_ACTIONS)) begin
                    r_seen <= r_seen + rapc_pkg::CNT_W'(1);
                end
                if (!r_latched) begin
                    priority if ((act.code != rapc_pkg::DENY_NONE) &&
                                 (act.code != rapc_pkg::DENY_ALIAS)) begin
                        r_latched     <= 1'b1;
                        r_denied_pos  <= r_seen;
                        r_denied_code <= act.code;
                    end else if (act.is_if_begin) begin
                        if (r_inside) begin
                            r_latched     <= 1'b1;
                            r_denied_pos  <= r_seen;
                            r_denied_code <= rapc_pkg::DENY_FLOW;
                        end else begin
                            r_inside <= 1'b1;
                        end
                    end else if (act.is_end_if) begin
                        if (!r_inside) begin
                            r_latched     <= 1'b1;
                            r_denied_pos  <= r_seen;
                            r_denied_code <= rapc_pkg::DENY_FLOW;
                        end else begin
                            r_inside <= 1'b0;
                        end
                    end else if (act.code == rapc_pkg::DENY_ALIAS) begin
                        r_alias_seen <= 1'b1;
                    end else begin
                        r_alias_seen <= r_alias_seen;
                    end
                end
            end
        end
    end

    // Report queue occupancy.
    always_comb begin
        n_rq_count = r_rq_count;
        if (rpt_push && !rpt_pop) begin
            n_rq_count = r_rq_count + 2'd1;
        end else if (rpt_pop && !rpt_push) begin
            n_rq_count = r_rq_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rq_wr    <= 1'b0;
            r_rq_rd    <= 1'b0;
            r_rq_count <= 2'd0;
        end else begin
            r_rq_count <= n_rq_count;
            if (rpt_push) begin
                r_rq_wr <= ~r_rq_wr;
            end
            if (rpt_pop) begin
                r_rq_rd <= ~r_rq_rd;
            end
        end
    end

    // Report storage.
    always_ff @(posedge i_clk) begin
        if (rpt_push) begin
            r_rq[r_rq_wr] <= report;
        end
    end

    assign o_rpt_empty = (r_rq_count == 2'd0);
    assign o_rpt       = r_rq[r_rq_rd];

endmodule
